FILE: rtl/tsnrd_pkg.sv
// Shared types, tag layout and constants for the time-series record deframer.
package tsnrd_pkg;

   // Input transaction payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_payload_type;

   // Result transaction payload
   typedef struct packed {
      logic [2:0]         kind;
      logic [2:0]         channel;
      logic signed [23:0] sample_value;
      logic [15:0]        scan_index;
      logic [23:0]        record_index;
      logic [7:0]         start_second;
      logic [7:0]         start_minute;
      logic [7:0]         start_hour;
      logic [7:0]         start_day;
      logic [7:0]         start_month;
      logic [11:0]        start_year;
      logic [15:0]        sample_rate;
   } rsp_payload_type;

   // Result kinds
   localparam logic [2:0] KIND_HEADER      = 3'd0;
   localparam logic [2:0] KIND_SAMPLE      = 3'd1;
   localparam logic [2:0] KIND_TAG_SIZE    = 3'd2;
   localparam logic [2:0] KIND_BAD_CHANNEL = 3'd3;
   localparam logic [2:0] KIND_BAD_UNIT    = 3'd4;

   // Time unit codes of the tag
   localparam logic [7:0] UNIT_SECOND = 8'd0;
   localparam logic [7:0] UNIT_MINUTE = 8'd1;
   localparam logic [7:0] UNIT_HOUR   = 8'd2;
   localparam logic [7:0] UNIT_DAY    = 8'd3;

   // Reciprocals for the constant divides: q = (x * M) >> S, exact for 16-bit x
   localparam logic [23:0] RECIP_MINUTE = 24'd4473925;
   localparam int          SHIFT_MINUTE = 28;
   localparam logic [23:0] RECIP_HOUR   = 24'd9544372;
   localparam int          SHIFT_HOUR   = 35;

   // Captured part of the tag and field positions within it
   localparam int CAP_LEN       = 21;
   localparam int IDX_SECOND    = 0;
   localparam int IDX_MINUTE    = 1;
   localparam int IDX_HOUR      = 2;
   localparam int IDX_DAY       = 3;
   localparam int IDX_MONTH     = 4;
   localparam int IDX_YEAR      = 5;
   localparam int IDX_SCANS_LO  = 10;
   localparam int IDX_SCANS_HI  = 11;
   localparam int IDX_CHANNELS  = 12;
   localparam int IDX_TAG_LEN   = 13;
   localparam int IDX_SLOT_LEN  = 17;
   localparam int IDX_RATE_LO   = 18;
   localparam int IDX_RATE_HI   = 19;
   localparam int IDX_UNIT      = 20;

   localparam logic [7:0] TAG_MIN_LEN   = 8'd21;
   localparam logic [7:0] SLOT_MIN_LEN  = 8'd3;
   localparam logic [7:0] TAG_SIZE_RST  = 8'd32;
   localparam logic [7:0] YEAR_PIVOT    = 8'd70;
   localparam logic [11:0] CENTURY_20   = 12'd2000;
   localparam logic [11:0] CENTURY_19   = 12'd1900;

   // Configuration register map
   localparam int         CSR_ADDR_BITS           = 3;
   localparam logic [2:0] ADDR_EXPECTED_TAG_SIZE  = 3'd0;

   // Slot to channel remap by channel count (count 3, 4 or 5)
   function automatic logic [2:0] chan_map(input logic [7:0] count, input logic [7:0] slot);
      logic [2:0] ch;
      ch = 3'd0;
      unique case (count)
         8'd3: begin
            unique case (slot)
               8'd0:    ch = 3'd2;
               8'd1:    ch = 3'd0;
               8'd2:    ch = 3'd1;
               default: ch = 3'd0;
            endcase
         end
         8'd4: begin
            unique case (slot)
               8'd0:    ch = 3'd2;
               8'd1:    ch = 3'd3;
               8'd2:    ch = 3'd0;
               8'd3:    ch = 3'd1;
               default: ch = 3'd0;
            endcase
         end
         8'd5: begin
            unique case (slot)
               8'd0:    ch = 3'd3;
               8'd1:    ch = 3'd4;
               8'd2:    ch = 3'd0;
               8'd3:    ch = 3'd1;
               8'd4:    ch = 3'd2;
               default: ch = 3'd0;
            endcase
         end
         default: ch = 3'd0;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/tsn_record_deframer.sv
// Top level of the record deframer: input register, parser, result register.
//
// Usage:
//   req_* carries one stream byte per transaction (data_byte, file_start);
//   a transaction is taken when req_valid is high and req_stall is low.
//   rsp_* returns header and sample results; the receiver holds rsp_stall
//   high to keep the current result in place.
//   The APB-style port (psel/penable/pwrite/paddr/pwdata) sets the expected
//   tag size; write it only while no byte is in flight.
// Timing:
//   A byte accepted into the input register is parsed from there, and its
//   result, if any, is captured in the result register and shows on rsp_*.
//   One byte per cycle sustained while rsp_stall is low; the path is the
//   parser logic between the input register and the result register.
// Reset: clears the valid bits of both pipeline registers, the parser state
//   and the record count; the expected tag size returns to 32.
// Stall: a held result keeps the parser waiting; the input register still
//   takes one more byte, then req_stall rises until the result is taken.
module tsn_record_deframer #(
   parameter int RECORD_COUNT_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tsnrd_pkg::req_payload_type         req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tsnrd_pkg::rsp_payload_type         rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsnrd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import tsnrd_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   req_payload_type in_item_ff,   in_item_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff,  out_item_in;
   logic            advance;
   logic            emit;
   rsp_payload_type result;
   logic [7:0]      expected_tag_size;

   tsnrd_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .expected_tag_size (expected_tag_size)
   );

   tsnrd_parser #(
      .RECORD_COUNT_BITS (RECORD_COUNT_BITS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .item              (in_item_ff),
      .expected_tag_size (expected_tag_size),
      .emit              (emit),
      .result            (result)
   );

   // the held byte moves on once the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_payload;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = emit;
         out_item_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

`ifndef NO_ASSERTIONS
   // back-pressure only comes from a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   // a new result only appears after a parse step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result appeared without a parse step");
`endif

endmodule

FILE: rtl/tsnrd_csr.sv
// Configuration register block: expected tag size over an APB-style port.
module tsnrd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsnrd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output logic [7:0]                         expected_tag_size
);
   import tsnrd_pkg::*;

   logic [7:0] tag_size_ff;
   logic [7:0] tag_size_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == ADDR_EXPECTED_TAG_SIZE);

   // register write
   always_comb begin
      tag_size_in = tag_size_ff;
      if (wr_en) begin
         tag_size_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_size_ff <= TAG_SIZE_RST;
      end else begin
         tag_size_ff <= tag_size_in;
      end
   end

   // read back
   always_comb begin
      prdata = 32'd0;
      if (paddr == ADDR_EXPECTED_TAG_SIZE) begin
         prdata = {24'd0, tag_size_ff};
      end
   end

   assign expected_tag_size = tag_size_ff;

endmodule

FILE: rtl/tsnrd_rate_div.sv
// Sample rate: tag rate divided by the time unit, by reciprocal multiply.
module tsnrd_rate_div (
   input  logic [15:0] denom,
   input  logic [7:0]  unit,
   output logic [15:0] rate,
   output logic        bad_unit
);
   import tsnrd_pkg::*;

   logic [23:0] recip;
   logic [39:0] prod;

   assign recip = (unit == UNIT_MINUTE) ? RECIP_MINUTE : RECIP_HOUR;
   assign prod  = {24'd0, denom} * {16'd0, recip};

   // a day is longer than any 16-bit rate, so it always truncates to zero
   always_comb begin
      bad_unit = 1'b0;
      unique case (unit)
         UNIT_SECOND: rate = denom;
         UNIT_MINUTE: rate = 16'(prod >> SHIFT_MINUTE);
         UNIT_HOUR:   rate = 16'(prod >> SHIFT_HOUR);
         UNIT_DAY:    rate = 16'd0;
         default: begin
            rate     = 16'd0;
            bad_unit = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/tsnrd_parser.sv
// Record parser: tag capture, scan/slot counters and result formation per byte.
module tsnrd_parser #(
   parameter int RECORD_COUNT_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  tsnrd_pkg::req_payload_type  item,
   input  logic [7:0]                  expected_tag_size,
   output logic                        emit,
   output tsnrd_pkg::rsp_payload_type  result
);
   import tsnrd_pkg::*;

   // parser state
   logic                         in_tag_ff,    in_tag_in;
   logic [7:0]                   tag_pos_ff,   tag_pos_in;
   logic [7:0]                   cap_ff [CAP_LEN];
   logic [15:0]                  scans_ff,     scans_in;
   logic [7:0]                   chan_cnt_ff,  chan_cnt_in;
   logic [7:0]                   slot_len_ff,  slot_len_in;
   logic [15:0]                  scan_cnt_ff,  scan_cnt_in;
   logic [7:0]                   slot_cnt_ff,  slot_cnt_in;
   logic [7:0]                   byte_cnt_ff,  byte_cnt_in;
   logic [15:0]                  low_bytes_ff, low_bytes_in;
   logic [RECORD_COUNT_BITS-1:0] rec_cnt_ff,   rec_cnt_in;
   logic                         skip_ff,      skip_in;

   // state as seen by this byte (file start clears it first)
   logic                         in_tag_cur;
   logic [7:0]                   tag_pos_cur;
   logic [15:0]                  scans_cur;
   logic [7:0]                   chan_cnt_cur;
   logic [7:0]                   slot_len_cur;
   logic [15:0]                  scan_cnt_cur;
   logic [7:0]                   slot_cnt_cur;
   logic [7:0]                   byte_cnt_cur;
   logic [15:0]                  low_bytes_cur;
   logic [RECORD_COUNT_BITS-1:0] rec_cnt_cur;
   logic                         skip_cur;

   logic [7:0]                   cap_view [CAP_LEN];
   logic [7:0]                   b;
   logic [7:0]                   need;
   logic                         tag_done;
   logic                         bad_ch;
   logic                         bad_unit;
   logic [15:0]                  rate;
   logic [15:0]                  new_scans;
   logic [7:0]                   new_chans;
   logic [7:0]                   year_byte;
   logic [RECORD_COUNT_BITS-1:0] rec_next;

   assign b = item.data_byte;

   always_comb begin
      if (item.file_start) begin
         in_tag_cur    = 1'b1;
         tag_pos_cur   = 8'd0;
         scans_cur     = 16'd0;
         chan_cnt_cur  = 8'd0;
         slot_len_cur  = SLOT_MIN_LEN;
         scan_cnt_cur  = 16'd0;
         slot_cnt_cur  = 8'd0;
         byte_cnt_cur  = 8'd0;
         low_bytes_cur = 16'd0;
         rec_cnt_cur   = '0;
         skip_cur      = 1'b0;
      end else begin
         in_tag_cur    = in_tag_ff;
         tag_pos_cur   = tag_pos_ff;
         scans_cur     = scans_ff;
         chan_cnt_cur  = chan_cnt_ff;
         slot_len_cur  = slot_len_ff;
         scan_cnt_cur  = scan_cnt_ff;
         slot_cnt_cur  = slot_cnt_ff;
         byte_cnt_cur  = byte_cnt_ff;
         low_bytes_cur = low_bytes_ff;
         rec_cnt_cur   = rec_cnt_ff;
         skip_cur      = skip_ff;
      end
   end

   // capture with this byte's write forwarded
   always_comb begin
      for (int i = 0; i < CAP_LEN; i++) begin
         cap_view[i] = (in_tag_cur && tag_pos_cur == 8'(i)) ? b : cap_ff[i];
      end
   end

   assign need      = (cap_view[IDX_TAG_LEN] < TAG_MIN_LEN) ? TAG_MIN_LEN
                                                             : cap_view[IDX_TAG_LEN];
   assign tag_done  = in_tag_cur && (tag_pos_cur >= 8'(CAP_LEN - 1))
                      && ({1'b0, tag_pos_cur} + 9'd1 >= {1'b0, need});
   assign new_scans = {cap_view[IDX_SCANS_HI], cap_view[IDX_SCANS_LO]};
   assign new_chans = cap_view[IDX_CHANNELS];
   assign bad_ch    = (new_chans < 8'd3) || (new_chans > 8'd5);
   assign year_byte = cap_view[IDX_YEAR];
   assign rec_next  = (rec_cnt_cur == '1) ? rec_cnt_cur : rec_cnt_cur + 1'b1;

   tsnrd_rate_div u_rate (
      .denom    ({cap_view[IDX_RATE_HI], cap_view[IDX_RATE_LO]}),
      .unit     (cap_view[IDX_UNIT]),
      .rate     (rate),
      .bad_unit (bad_unit)
   );

   // next state and result for one byte
   always_comb begin
      in_tag_in    = in_tag_cur;
      tag_pos_in   = tag_pos_cur;
      scans_in     = scans_cur;
      chan_cnt_in  = chan_cnt_cur;
      slot_len_in  = slot_len_cur;
      scan_cnt_in  = scan_cnt_cur;
      slot_cnt_in  = slot_cnt_cur;
      byte_cnt_in  = byte_cnt_cur;
      low_bytes_in = low_bytes_cur;
      rec_cnt_in   = rec_cnt_cur;
      skip_in      = skip_cur;
      emit         = 1'b0;
      result       = '0;

      if (in_tag_cur) begin
         if (tag_done) begin
            // header transaction
            emit = 1'b1;
            priority if (bad_ch) begin
               result.kind = KIND_BAD_CHANNEL;
            end else if (bad_unit) begin
               result.kind = KIND_BAD_UNIT;
            end else if (cap_view[IDX_TAG_LEN] != expected_tag_size) begin
               result.kind = KIND_TAG_SIZE;
            end else begin
               result.kind = KIND_HEADER;
            end
            result.record_index = 24'(rec_cnt_cur);
            result.start_second = cap_view[IDX_SECOND];
            result.start_minute = cap_view[IDX_MINUTE];
            result.start_hour   = cap_view[IDX_HOUR];
            result.start_day    = cap_view[IDX_DAY];
            result.start_month  = cap_view[IDX_MONTH];
            result.start_year   = (year_byte < YEAR_PIVOT) ? CENTURY_20 + {4'd0, year_byte}
                                                           : CENTURY_19 + {4'd0, year_byte};
            result.sample_rate  = rate;

            scans_in     = new_scans;
            chan_cnt_in  = new_chans;
            slot_len_in  = (cap_view[IDX_SLOT_LEN] < SLOT_MIN_LEN) ? SLOT_MIN_LEN
                                                                   : cap_view[IDX_SLOT_LEN];
            in_tag_in    = 1'b0;
            tag_pos_in   = 8'd0;
            scan_cnt_in  = 16'd0;
            slot_cnt_in  = 8'd0;
            byte_cnt_in  = 8'd0;
            low_bytes_in = 16'd0;
            skip_in      = bad_ch;
            // empty record: straight on to the next tag
            if ((new_scans == 16'd0) || (new_chans == 8'd0)) begin
               in_tag_in  = 1'b1;
               skip_in    = 1'b0;
               rec_cnt_in = rec_next;
            end
         end else begin
            tag_pos_in = tag_pos_cur + 8'd1;
         end
      end else begin
         // sample bytes
         if (byte_cnt_cur == 8'd0) begin
            low_bytes_in = {8'd0, b};
         end else if (byte_cnt_cur == 8'd1) begin
            low_bytes_in = {b, low_bytes_cur[7:0]};
         end else if ((byte_cnt_cur == 8'd2) && !skip_cur) begin
            emit                = 1'b1;
            result.kind         = KIND_SAMPLE;
            result.channel      = chan_map(chan_cnt_cur, slot_cnt_cur);
            result.sample_value = $signed({b, low_bytes_cur});
            result.scan_index   = scan_cnt_cur;
            result.record_index = 24'(rec_cnt_cur);
         end

         if ({1'b0, byte_cnt_cur} + 9'd1 >= {1'b0, slot_len_cur}) begin
            byte_cnt_in = 8'd0;
            if ({1'b0, slot_cnt_cur} + 9'd1 >= {1'b0, chan_cnt_cur}) begin
               slot_cnt_in = 8'd0;
               if ({1'b0, scan_cnt_cur} + 17'd1 >= {1'b0, scans_cur}) begin
                  scan_cnt_in = 16'd0;
                  in_tag_in   = 1'b1;
                  tag_pos_in  = 8'd0;
                  skip_in     = 1'b0;
                  rec_cnt_in  = rec_next;
               end else begin
                  scan_cnt_in = scan_cnt_cur + 16'd1;
               end
            end else begin
               slot_cnt_in = slot_cnt_cur + 8'd1;
            end
         end else begin
            byte_cnt_in = byte_cnt_cur + 8'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff    <= 1'b1;
         tag_pos_ff   <= 8'd0;
         scans_ff     <= 16'd0;
         chan_cnt_ff  <= 8'd0;
         slot_len_ff  <= SLOT_MIN_LEN;
         scan_cnt_ff  <= 16'd0;
         slot_cnt_ff  <= 8'd0;
         byte_cnt_ff  <= 8'd0;
         low_bytes_ff <= 16'd0;
         rec_cnt_ff   <= '0;
         skip_ff      <= 1'b0;
      end else if (step) begin
         in_tag_ff    <= in_tag_in;
         tag_pos_ff   <= tag_pos_in;
         scans_ff     <= scans_in;
         chan_cnt_ff  <= chan_cnt_in;
         slot_len_ff  <= slot_len_in;
         scan_cnt_ff  <= scan_cnt_in;
         slot_cnt_ff  <= slot_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         low_bytes_ff <= low_bytes_in;
         rec_cnt_ff   <= rec_cnt_in;
         skip_ff      <= skip_in;
      end
   end

   // tag capture, no reset: every entry is written before a header reads it
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAP_LEN; i++) begin
         if (step && in_tag_cur && (tag_pos_cur == 8'(i))) begin
            cap_ff[i] <= b;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // slot counters sit at zero whenever a tag is expected
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      in_tag_ff |-> (byte_cnt_ff == 8'd0 && slot_cnt_ff == 8'd0 && scan_cnt_ff == 16'd0))
      else $error("slot counters not cleared while parsing a tag");

   // byte position stays inside the effective slot
   a_byte_in_slot: assert property (@(posedge clock) disable iff (reset)
      !in_tag_ff |-> (slot_len_ff >= SLOT_MIN_LEN && byte_cnt_ff < slot_len_ff))
      else $error("byte position beyond slot length");

   // decoded records always have a valid channel count
   a_valid_channels: assert property (@(posedge clock) disable iff (reset)
      (!in_tag_ff && !skip_ff) |->
         (chan_cnt_ff >= 8'd3 && chan_cnt_ff <= 8'd5 && slot_cnt_ff < chan_cnt_ff))
      else $error("decoding a record with a bad channel count");
`endif

endmodule
